### rtl/edc_pkg.sv
// shared constants and types for the unit-cost edit distance block
package edc_pkg;

	localparam int MAX_LEN = 64;
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int DIST_W = 16;
	localparam int SUM_W = DIST_W + 1;

	localparam logic [SUM_W-1:0] INS_STEP = SUM_W'(1);
	localparam logic [SUM_W-1:0] DEL_STEP = SUM_W'(1);
	localparam logic [SUM_W-1:0] SUB_STEP = SUM_W'(1);
	localparam logic [DIST_W-1:0] TEXT_LIMIT = 16'hFFFF;
	localparam logic [SUM_W-1:0] DIST_SAT = SUM_W'(16'hFFFF);

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_TEXT   = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} res_t;

	// one text byte moving along the row
	typedef struct packed {
		logic              valid;
		logic [7:0]        ch;
		logic [DIST_W-1:0] left;
		logic [DIST_W-1:0] diag;
		logic [DIST_W-1:0] tlen;
	} wave_t;

	// finish marker that picks up the last pattern column on its way
	typedef struct packed {
		logic              valid;
		logic              capture;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] score;
	} token_t;

	typedef struct packed {
		wave_t  wave;
		token_t token;
	} link_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       ch;
	} load_t;

endpackage

### rtl/edc_cell.sv
// one pattern column of the dp row: stored byte, stored entry, link register
module edc_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [edc_pkg::IDX_W-1:0] cell_idx,
	input  edc_pkg::load_t         load,
	input  edc_pkg::link_t         link_in,
	output edc_pkg::link_t         link_out
);
	import edc_pkg::*;

	logic [7:0]        pat_q;
	logic [DIST_W-1:0] val_q;

	// link register, data and control
	logic              wave_valid_q;
	logic [7:0]        ch_q;
	logic [DIST_W-1:0] left_q;
	logic [DIST_W-1:0] diag_q;
	logic [DIST_W-1:0] tlen_q;
	logic              tok_valid_q;
	logic              capture_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DIST_W-1:0] score_q;

	logic [SUM_W-1:0] up;
	logic [SUM_W-1:0] del_c;
	logic [SUM_W-1:0] ins_c;
	logic [SUM_W-1:0] sub_c;
	logic [SUM_W-1:0] m1;
	logic [SUM_W-1:0] m2;
	logic [DIST_W-1:0] v;

	// first text byte sees the boundary row d(0,j) = j
	always_comb begin
		if (link_in.wave.tlen == '0) begin
			up = SUM_W'(cell_idx) + SUM_W'(1);
		end else begin
			up = SUM_W'(val_q);
		end
		del_c = up + DEL_STEP;
		ins_c = SUM_W'(link_in.wave.left) + INS_STEP;
		sub_c = SUM_W'(link_in.wave.diag) + ((pat_q == link_in.wave.ch) ? '0 : SUB_STEP);
		m1 = (del_c < ins_c) ? del_c : ins_c;
		m2 = (m1 < sub_c) ? m1 : sub_c;
		v = (m2 > DIST_SAT) ? DIST_SAT[DIST_W-1:0] : m2[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (load.en && load.idx == cell_idx) begin
			pat_q <= load.ch;
		end
		if (link_in.wave.valid) begin
			val_q <= v;
		end
	end

	// link payload
	always_ff @(posedge clk) begin
		ch_q   <= link_in.wave.ch;
		left_q <= v;
		diag_q <= up[DIST_W-1:0];
		tlen_q <= link_in.wave.tlen;
		idx_q  <= link_in.token.idx;
		if (link_in.token.capture && link_in.token.idx == cell_idx) begin
			score_q <= val_q;
		end else begin
			score_q <= link_in.token.score;
		end
	end

	// link control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_valid_q <= 1'b0;
			tok_valid_q  <= 1'b0;
			capture_q    <= 1'b0;
		end else begin
			wave_valid_q <= link_in.wave.valid;
			tok_valid_q  <= link_in.token.valid;
			capture_q    <= link_in.token.capture
				&& (link_in.token.idx != cell_idx);
		end
	end

	always_comb begin
		link_out.wave.valid    = wave_valid_q;
		link_out.wave.ch       = ch_q;
		link_out.wave.left     = left_q;
		link_out.wave.diag     = diag_q;
		link_out.wave.tlen     = tlen_q;
		link_out.token.valid   = tok_valid_q;
		link_out.token.capture = capture_q;
		link_out.token.idx     = idx_q;
		link_out.token.score   = score_q;
	end

endmodule

### rtl/edc_chain.sv
// row of cells, one per pattern byte, linked head to tail
module edc_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  edc_pkg::load_t load,
	input  edc_pkg::link_t head,
	output edc_pkg::link_t tail
);
	import edc_pkg::*;

	link_t links [MAX_LEN+1];

	assign links[0] = head;

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		edc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.load     (load),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	assign tail = links[MAX_LEN];

endmodule

### rtl/edit_distance_unit_cost.sv
// top level of the unit-cost edit distance block
// usage: each request carries an action and a byte. load requests store the first
//   string into the cell row, one byte per cell; text requests stream the second
//   string through the row; a finish request returns one response with the
//   distance and the overflow flag and clears the block for the next pair
// throughput: load and text requests are taken one per cycle, back to back, while
//   no finish marker is in the row. a text byte enters cell 0 and the wavefront
//   moves one cell per cycle, so the row keeps up to MAX_LEN bytes in flight
// finish: a finish marker follows the last text byte down the row and picks up
//   the entry of the last pattern column; at the end of the row its score is
//   registered as the response. while the marker is in the row, no request is
//   taken
// stall: the response sits in an output register until taken. load and text
//   requests are still taken meanwhile; a finish request waits until the
//   previous response has gone
// reset: arst_n clears lengths, flags and the row's control bits; stored
//   pattern bytes and row entries are written before they are read
module edit_distance_unit_cost (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  edc_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output edc_pkg::res_t res
);
	import edc_pkg::*;

	// pair state
	logic [LEN_W-1:0]  plen_q;
	logic [DIST_W-1:0] tlen_q;
	logic              started_q;
	logic              ovf_q;

	// finish marker in flight and its overflow flag
	logic busy_q;
	logic res_ovf_q;

	// response register
	logic res_valid_q;
	res_t res_q;

	logic  req_acc;
	logic  is_load;
	logic  is_text;
	logic  is_finish;
	load_t load;
	link_t head;
	link_t tail;

	// a finish waits for the response register to be free
	assign req_stall = busy_q || (res_valid_q && req.action == ACT_FINISH);
	assign req_acc   = req_valid && !req_stall;
	assign is_load   = req_acc && req.action == ACT_LOAD;
	assign is_text   = req_acc && req.action == ACT_TEXT;
	assign is_finish = req_acc && req.action == ACT_FINISH;

	// pattern write into the next free cell
	always_comb begin
		load.en  = is_load && !started_q && (plen_q < LEN_W'(MAX_LEN));
		load.idx = plen_q[IDX_W-1:0];
		load.ch  = req.ch;
	end

	// feed cell 0: text byte with the boundary column d(i,0), or finish marker
	always_comb begin
		head.wave.valid = is_text && (tlen_q != TEXT_LIMIT);
		head.wave.ch    = req.ch;
		head.wave.left  = tlen_q + DIST_W'(1);
		head.wave.diag  = tlen_q;
		head.wave.tlen  = tlen_q;

		head.token.valid   = is_finish;
		head.token.capture = (tlen_q != '0) && (plen_q != '0);
		head.token.idx     = IDX_W'(plen_q - LEN_W'(1));
		// empty strings: the distance is the other string's length
		if (tlen_q == '0) begin
			head.token.score = DIST_W'(plen_q);
		end else begin
			head.token.score = tlen_q;
		end
	end

	edc_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.head   (head),
		.tail   (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			tlen_q    <= '0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
			busy_q    <= 1'b0;
			res_ovf_q <= 1'b0;
		end else begin
			if (is_load && !started_q) begin
				if (plen_q < LEN_W'(MAX_LEN)) begin
					plen_q <= plen_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (is_text) begin
				started_q <= 1'b1;
				if (tlen_q == TEXT_LIMIT) begin
					ovf_q <= 1'b1;
				end else begin
					tlen_q <= tlen_q + DIST_W'(1);
				end
			end
			// finish clears the pair state right away; the marker carries the rest
			if (is_finish) begin
				plen_q    <= '0;
				tlen_q    <= '0;
				started_q <= 1'b0;
				ovf_q     <= 1'b0;
				res_ovf_q <= ovf_q;
				busy_q    <= 1'b1;
			end
			if (tail.token.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (tail.token.valid) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.token.valid) begin
			res_q.distance <= tail.token.score;
			res_q.overflow <= res_ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### tb/sv/edc_checker.sv
// request and response monitor with a distance predictor for the edit distance block
`timescale 1ns / 100ps

module edc_checker
	import edc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   errors,
	output int   owed
);

	logic [7:0]  pattern [MAX_LEN];
	logic [15:0] row [MAX_LEN];
	int unsigned pat_len;
	int unsigned txt_len;
	bit          txt_begun;
	bit          ovf_seen;
	res_t        owed_q [$];
	res_t        want;

	task automatic clear_pair();
		pat_len   = 0;
		txt_len   = 0;
		txt_begun = 0;
		ovf_seen  = 0;
	endtask

	// one text byte moves the row from D(i-1, *) to D(i, *)
	task automatic absorb_text(input logic [7:0] c);
		int unsigned diag;
		int unsigned left;
		int unsigned up;
		int unsigned sub;
		int unsigned v;
		int unsigned j;
		diag = txt_len;
		left = txt_len + 1;
		for (j = 1; j <= pat_len; j++) begin
			up  = (txt_len == 0) ? j : int'(row[j-1]);
			sub = diag + ((pattern[j-1] == c) ? 0 : 1);
			v   = up + 1;
			if (left + 1 < v)
				v = left + 1;
			if (sub < v)
				v = sub;
			if (v > 16'hFFFF)
				v = 16'hFFFF;
			row[j-1] = v[15:0];
			diag = up;
			left = v;
		end
		txt_len++;
	endtask

	task automatic track_request(input req_t r);
		res_t d;
		case (r.action)
			ACT_LOAD: begin
				if (!txt_begun) begin
					if (pat_len < MAX_LEN) begin
						pattern[pat_len] = r.ch;
						pat_len++;
					end else
						ovf_seen = 1;
				end
			end
			ACT_TEXT: begin
				txt_begun = 1;
				if (txt_len >= 16'hFFFF)
					ovf_seen = 1;
				else
					absorb_text(r.ch);
			end
			ACT_FINISH: begin
				if (txt_len == 0)
					d.distance = pat_len[15:0];
				else if (pat_len == 0)
					d.distance = txt_len[15:0];
				else
					d.distance = row[pat_len-1];
				d.overflow = ovf_seen;
				owed_q.push_back(d);
				clear_pair();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_pair();
			owed_q.delete();
			errors = 0;
			owed   = 0;
		end else begin
			// results first, so a stray one never pairs with a finish taken this edge
			if (res_valid && !res_stall) begin
				if (owed_q.size() == 0) begin
					$display("%0t unexpected response: distance %0d overflow %0b",
						$time, res.distance, res.overflow);
					errors++;
				end else begin
					want = owed_q.pop_front();
					if (res.distance !== want.distance) begin
						$display("%0t distance mismatch: expected %0d, actual %0d",
							$time, want.distance, res.distance);
						errors++;
					end
					if (res.overflow !== want.overflow) begin
						$display("%0t overflow mismatch: expected %0b, actual %0b",
							$time, want.overflow, res.overflow);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall)
				track_request(req);
			owed = owed_q.size();
		end
	end

endmodule

### tb/sv/tb_edit_distance_unit_cost.sv
// top of the edit distance testbench: clock, reset, request and stall stimulus, verdict
`timescale 1ns / 100ps

module tb_edit_distance_unit_cost;
	import edc_pkg::*;

	localparam int RANDOM_ITEMS = 880;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 1000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;

	int errors;
	int owed;
	int cycles;
	int pair_items;
	bit calm;      // no idling on either side while set
	bit hold_off;  // asks the response side for one long stall
	bit squeezed;

	edit_distance_unit_cost u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	edc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.errors    (errors),
		.owed      (owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, counted in cycles from time zero
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t timeout with %0d responses still owed", $time, owed);
		$display("status: fail");
		$finish;
	end

	// response side: random stall, or one long hold-off on request
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				// block keeps taking requests until a finish meets its full output register
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 0;
			end else
				res_stall <= !calm && ($urandom_range(99) < 22);
		end
	end

	// offer one request; returns at the edge that takes it
	task automatic push_request(input action_t act, input logic [7:0] c);
		// random gaps in front of the request
		while (!calm && $urandom_range(99) < 22) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req.action <= act;
		req.ch     <= c;
		// req_stall is read before this edge's updates land
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// narrow alphabet makes matches common, otherwise any byte
	function automatic logic [7:0] pick_byte(input bit narrow, input logic [7:0] base);
		return narrow ? base + 8'($urandom_range(3)) : 8'($urandom_range(255));
	endfunction

	// one pair: mostly well formed, sometimes overlong, late loads or dead actions
	task automatic random_pair();
		int          plen;
		int          tlen;
		int          flavor;
		int          i;
		bit          narrow;
		logic [7:0]  base;
		flavor = $urandom_range(99);
		narrow = $urandom_range(1);
		base   = 8'($urandom_range(252));
		plen   = ($urandom_range(15) == 0) ? $urandom_range(9, MAX_LEN) : $urandom_range(0, 8);
		tlen   = ($urandom_range(15) == 0) ? $urandom_range(9, 80) : $urandom_range(0, 8);
		for (i = 0; i < plen; i++) begin
			push_request(ACT_LOAD, pick_byte(narrow, base));
			pair_items++;
		end
		// extra pattern bytes; past the row length they are dropped and overflow raised
		if (flavor < 5) begin
			for (i = 0; i < int'($urandom_range(1, 3)); i++)
				push_request(ACT_LOAD, pick_byte(narrow, base));
		end
		for (i = 0; i < tlen; i++) begin
			push_request(ACT_TEXT, pick_byte(narrow, base));
			pair_items++;
			// load after text has begun is ignored
			if (flavor >= 5 && flavor < 12 && i == tlen / 2)
				push_request(ACT_LOAD, pick_byte(narrow, base));
		end
		// unused action code changes nothing
		if (flavor >= 12 && flavor < 18)
			push_request(ACT_NONE, 8'($urandom_range(255)));
		push_request(ACT_FINISH, 8'($urandom_range(255)));
		pair_items++;
	endtask

	initial begin
		int i;
		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		req        <= '0;
		calm       = 0;
		hold_off   = 0;
		squeezed   = 0;
		pair_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pair, with a dead action in front
		push_request(ACT_NONE, 8'hFF);
		push_request(ACT_FINISH, 8'h00);
		// byte extremes, two substitutions
		push_request(ACT_LOAD, 8'h00);
		push_request(ACT_LOAD, 8'hFF);
		push_request(ACT_TEXT, 8'hFF);
		push_request(ACT_TEXT, 8'h00);
		push_request(ACT_FINISH, 8'hFF);
		// no text: distance is the pattern length
		push_request(ACT_LOAD, 8'h61);
		push_request(ACT_LOAD, 8'h62);
		push_request(ACT_LOAD, 8'h63);
		push_request(ACT_FINISH, 8'h00);
		// no pattern: distance is the text length
		push_request(ACT_TEXT, 8'h01);
		push_request(ACT_TEXT, 8'h02);
		push_request(ACT_TEXT, 8'h03);
		push_request(ACT_FINISH, 8'h00);
		// late load and a dead action in the middle of the text
		push_request(ACT_LOAD, 8'h6B);
		push_request(ACT_TEXT, 8'h6B);
		push_request(ACT_LOAD, 8'h7A);
		push_request(ACT_NONE, 8'h55);
		push_request(ACT_TEXT, 8'h78);
		push_request(ACT_FINISH, 8'hAA);

		// full row, no overflow
		for (i = 0; i < MAX_LEN; i++)
			push_request(ACT_LOAD, 8'($urandom_range(3)));
		for (i = 0; i < MAX_LEN; i++)
			push_request(ACT_TEXT, 8'($urandom_range(3)));
		push_request(ACT_FINISH, 8'h00);
		// one pattern byte too many
		for (i = 0; i <= MAX_LEN; i++)
			push_request(ACT_LOAD, 8'($urandom_range(255)));
		push_request(ACT_TEXT, 8'h41);
		push_request(ACT_TEXT, 8'h42);
		push_request(ACT_FINISH, 8'h00);

		// random pairs; a stretch without gaps, then one long response hold-off
		while (pair_items < RANDOM_ITEMS) begin
			calm = (pair_items >= 400 && pair_items < 560);
			if (!squeezed && pair_items >= 700) begin
				squeezed = 1;
				hold_off = 1;
			end
			random_pair();
		end
		calm = 0;
		req_valid <= 1'b0;

		// drain: all responses back, then room for a stray one
		while (owed != 0)
			@(posedge clk);
		repeat (MAX_LEN + 8) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
